>>> sv/pads_pkg.sv
// ----------------------------------------------------------------------------
// pads_pkg: shared types and constants for the periodic stencil block
// Defaults, field widths, register indexes and control bundles.
// ----------------------------------------------------------------------------
package pads_pkg;

  // Default geometry and sample width
  localparam int DEF_GRID_ROWS   = 64;
  localparam int DEF_GRID_COLS   = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int IDX_W      = 6;   // row / col port width
  localparam int SHIFT_W    = 6;   // shift register write width
  localparam int GAIN_W     = 32;  // diffusion gain, unsigned Q0.32
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam int              RST_SHIFT_ROWS = 1;
  localparam int              RST_SHIFT_COLS = 1;
  localparam logic [GAIN_W-1:0] RST_DIFF_GAIN = 32'd5;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_ROWS = 2'd0,
    REG_SHIFT_COLS = 2'd1,
    REG_DIFF_GAIN  = 2'd2
  } cfg_reg_t;

  // Top -> fill tracker
  typedef struct packed {
    logic check;   // read written flag of a cell being stored
    logic commit;  // mark that cell written, bump count if new
  } fill_cmd_t;

  // Fill tracker -> top
  typedef struct packed {
    logic clearing;  // flag sweep after reset in progress
    logic full;      // every cell written at least once
  } fill_stat_t;

  // Top -> arithmetic stages
  typedef struct packed {
    logic ld_lap;
    logic ld_prod;
  } math_ctl_t;

endpackage

>>> sv/pads_ram.sv
// ----------------------------------------------------------------------------
// pads_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pads_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/pads_fill.sv
// ----------------------------------------------------------------------------
// pads_fill: frame fill tracker
// One written flag per cell in RAM, cleared by a sweep after reset,
// plus a count of distinct cells written.
// ----------------------------------------------------------------------------
module pads_fill #(
  parameter int CELLS = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pads_pkg::fill_cmd_t      cmd,
  input  logic [$clog2(CELLS)-1:0] check_addr,
  input  logic [$clog2(CELLS)-1:0] commit_addr,
  output pads_pkg::fill_stat_t     stat
);
  import pads_pkg::*;

  localparam int AW   = $clog2(CELLS);
  localparam int CNTW = $clog2(CELLS + 1);

  logic            clearing_r;
  logic [AW-1:0]   clr_addr_r;
  logic [CNTW-1:0] fill_cnt_r;
  logic            flag_we;
  logic [AW-1:0]   flag_waddr;
  logic            flag_seen;

  assign flag_we    = clearing_r | cmd.commit;
  assign flag_waddr = clearing_r ? clr_addr_r : commit_addr;

  pads_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (!clearing_r),
    .re    (cmd.check),
    .raddr (check_addr),
    .rdata (flag_seen)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      fill_cnt_r <= '0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(CELLS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      // first store to a cell
      if (cmd.commit && !flag_seen) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end
    end
  end

  assign stat.clearing = clearing_r;
  assign stat.full     = (fill_cnt_r == CNTW'(CELLS));

endmodule

>>> sv/pads_math.sv
// ----------------------------------------------------------------------------
// pads_math: stencil arithmetic
// Laplacian stage, gain multiply stage, floor scale and saturating add.
// ----------------------------------------------------------------------------
module pads_math #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  pads_pkg::math_ctl_t           ctl,
  input  logic [pads_pkg::GAIN_W-1:0]   gain,
  input  logic signed [SAMPLE_BITS-1:0] ctr,
  input  logic signed [SAMPLE_BITS-1:0] nbr_n,
  input  logic signed [SAMPLE_BITS-1:0] nbr_s,
  input  logic signed [SAMPLE_BITS-1:0] nbr_w,
  input  logic signed [SAMPLE_BITS-1:0] nbr_e,
  input  logic signed [SAMPLE_BITS-1:0] adv,
  output logic [SAMPLE_BITS-1:0]        value,
  output logic                          saturated
);
  import pads_pkg::*;

  localparam int SW   = SAMPLE_BITS;
  localparam int LW   = SW + 3;          // Laplacian
  localparam int PW   = LW + GAIN_W + 1; // signed product
  localparam int TW   = PW - GAIN_W;     // product >> 32
  localparam int SUMW = TW + 1;

  localparam logic signed [SUMW-1:0] SMAX = SUMW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] SMIN = SUMW'(-(64'sd1 <<< (SW - 1)));

  logic signed [LW-1:0]     lap_nxt;
  logic signed [LW-1:0]     lap_r;
  logic signed [SW-1:0]     adv1_r;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PW-1:0]     prod_nxt;
  logic signed [PW-1:0]     prod_r;
  logic signed [SW-1:0]     adv2_r;
  logic signed [TW-1:0]     term;
  logic signed [SUMW-1:0]   sum;

  assign lap_nxt = LW'(nbr_n) + LW'(nbr_s) + LW'(nbr_w) + LW'(nbr_e) - (LW'(ctr) <<< 2);
  assign gain_s   = {1'b0, gain};
  assign prod_nxt = lap_r * gain_s;

  always_ff @(posedge clk) begin
    if (ctl.ld_lap) begin
      lap_r  <= lap_nxt;
      adv1_r <= adv;
    end
    if (ctl.ld_prod) begin
      prod_r <= prod_nxt;
      adv2_r <= adv1_r;
    end
  end

  // arithmetic shift by 32 = floor of gain * lap / 2^32
  assign term = prod_r[PW-1:GAIN_W];
  assign sum  = SUMW'(adv2_r) + SUMW'(term);

  always_comb begin
    if (sum > SMAX) begin
      value     = SMAX[SW-1:0];
      saturated = 1'b1;
    end else if (sum < SMIN) begin
      value     = SMIN[SW-1:0];
      saturated = 1'b1;
    end else begin
      value     = sum[SW-1:0];
      saturated = 1'b0;
    end
  end

endmodule

>>> sv/periodic_advect_diffuse_stencil_top.sv
// ----------------------------------------------------------------------------
// periodic_advect_diffuse_stencil_top: periodic advection-diffusion stencil
// Holds one wrapped 2D frame in RAM; returns advected sample plus gain-scaled
// five-point Laplacian per requested cell, saturated to the sample range.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                           Dir  Beat
//  --------  ----------------------------------------------  ---  -----------------
//  input     in_valid/in_ready, in_operation, in_row,        in   one write or compute
//            in_col, in_sample
//  result    out_valid/out_ready, out_value, out_saturated   out  one per compute
//  config    cfg_we, cfg_idx, cfg_data                       in   one register write
//
//  Write beat: sample store plus written-flag read-modify-write.
//  Compute beat: six grid words come from three mirrored grid RAMs, three
//    per cycle in S_RD0 and S_RD1, then the Laplacian (S_LAP), the gain
//    multiply (S_MUL) and the saturating add (S_SUM) follow in turn, and
//    S_SUM loads the result into the output register.
//  Reset: after rst_n the written-flag RAM is swept, one cell per cycle,
//    over all ROWS*COLS cells (4096 at 64x64); in_ready stays low meanwhile.
//  Stalls: a finished result waits in the output register; the next beat is
//    taken meanwhile, and a compute only holds at its last step if the
//    output register is still full.
//  Computes before every cell has been written, and out-of-range cells,
//    are accepted and dropped.
//
module periodic_advect_diffuse_stencil_top #(
  parameter int GRID_ROWS   = pads_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS   = pads_pkg::DEF_GRID_COLS,
  parameter int SAMPLE_BITS = pads_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [pads_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pads_pkg::CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [pads_pkg::IDX_W-1:0]      in_row,
  input  logic [pads_pkg::IDX_W-1:0]      in_col,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  // result beats
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_BITS-1:0]          out_value,
  output logic                            out_saturated
);
  import pads_pkg::*;

  localparam int CELLS      = GRID_ROWS * GRID_COLS;
  localparam int AW         = $clog2(CELLS);
  localparam int RW         = $clog2(GRID_ROWS);
  localparam int CW         = $clog2(GRID_COLS);
  localparam int SW         = SAMPLE_BITS;
  localparam int NCOPY      = 3;
  localparam int SHIFT_VALS = 2 ** SHIFT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WFLAG,
    S_RD0,
    S_RD1,
    S_LAP,
    S_MUL,
    S_SUM
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    cell_addr = AW'(32'(r) * GRID_COLS) + AW'(c);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration; shifts are stored already reduced mod grid size
  // --------------------------------------------------------------------------
  logic [RW-1:0]     row_shift_tab [SHIFT_VALS];
  logic [CW-1:0]     col_shift_tab [SHIFT_VALS];
  logic [RW-1:0]     shift_rows_r;
  logic [CW-1:0]     shift_cols_r;
  logic [GAIN_W-1:0] gain_r;

  for (genvar i = 0; i < SHIFT_VALS; i++) begin : g_shift_tab
    assign row_shift_tab[i] = RW'(i % GRID_ROWS);
    assign col_shift_tab[i] = CW'(i % GRID_COLS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_rows_r <= RW'(RST_SHIFT_ROWS % GRID_ROWS);
      shift_cols_r <= CW'(RST_SHIFT_COLS % GRID_COLS);
      gain_r       <= RST_DIFF_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SHIFT_ROWS: shift_rows_r <= row_shift_tab[cfg_data[SHIFT_W-1:0]];
        REG_SHIFT_COLS: shift_cols_r <= col_shift_tab[cfg_data[SHIFT_W-1:0]];
        REG_DIFF_GAIN:  gain_r       <= cfg_data[GAIN_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  state_t     state_r, state_nxt;
  fill_stat_t fill_stat;
  fill_cmd_t  fill_cmd;
  logic       in_fire;
  logic       in_rng;
  logic [RW-1:0] in_r;
  logic [CW-1:0] in_c;
  logic [AW-1:0] in_addr;
  logic          grd_we;

  assign in_ready = (state_r == S_IDLE) && !fill_stat.clearing;
  assign in_fire  = in_valid && in_ready;
  assign in_rng   = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
  assign in_r     = RW'(in_row);
  assign in_c     = CW'(in_col);
  assign in_addr  = cell_addr(in_r, in_c);
  assign grd_we   = in_fire && (in_operation == OP_WRITE) && in_rng;

  // item registers (payload, no reset)
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [AW-1:0] addr_r;
  logic [SW-1:0] ctr_r, nbr_n_r, nbr_s_r;
  logic [SW-1:0] grd_rdata [NCOPY];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r  <= in_r;
      col_r  <= in_c;
      addr_r <= in_addr;
    end
    if (state_r == S_RD1) begin
      ctr_r   <= grd_rdata[0];
      nbr_n_r <= grd_rdata[1];
      nbr_s_r <= grd_rdata[2];
    end
  end

  // --------------------------------------------------------------------------
  // Fill tracking
  // --------------------------------------------------------------------------
  assign fill_cmd.check  = grd_we;
  assign fill_cmd.commit = (state_r == S_WFLAG);

  pads_fill #(
    .CELLS (CELLS)
  ) u_fill (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (fill_cmd),
    .check_addr  (in_addr),
    .commit_addr (addr_r),
    .stat        (fill_stat)
  );

  // --------------------------------------------------------------------------
  // Stencil addressing with wraparound
  // --------------------------------------------------------------------------
  logic [RW-1:0] r_up, r_dn, r_adv;
  logic [CW-1:0] c_up, c_dn, c_adv;
  logic [AW-1:0] grd_raddr [NCOPY];
  logic          grd_re;

  assign r_up  = (row_r == RW'(GRID_ROWS - 1)) ? '0 : row_r + 1'b1;
  assign r_dn  = (row_r == '0) ? RW'(GRID_ROWS - 1) : row_r - 1'b1;
  assign c_up  = (col_r == CW'(GRID_COLS - 1)) ? '0 : col_r + 1'b1;
  assign c_dn  = (col_r == '0) ? CW'(GRID_COLS - 1) : col_r - 1'b1;
  // row - shift, plus the grid size when it would go negative
  assign r_adv = (row_r >= shift_rows_r) ? row_r - shift_rows_r
                                         : row_r + RW'(GRID_ROWS) - shift_rows_r;
  assign c_adv = (col_r >= shift_cols_r) ? col_r - shift_cols_r
                                         : col_r + CW'(GRID_COLS) - shift_cols_r;

  assign grd_re = (state_r == S_RD0) || (state_r == S_RD1);

  always_comb begin
    if (state_r == S_RD0) begin
      grd_raddr[0] = cell_addr(row_r, col_r);
      grd_raddr[1] = cell_addr(r_dn, col_r);
      grd_raddr[2] = cell_addr(r_up, col_r);
    end else begin
      grd_raddr[0] = cell_addr(row_r, c_dn);
      grd_raddr[1] = cell_addr(row_r, c_up);
      grd_raddr[2] = cell_addr(r_adv, c_adv);
    end
  end

  // Three mirrored copies of the frame, written together
  for (genvar k = 0; k < NCOPY; k++) begin : g_grid
    pads_ram #(
      .WIDTH (SW),
      .DEPTH (CELLS)
    ) u_grid_ram (
      .clk   (clk),
      .we    (grd_we),
      .waddr (in_addr),
      .wdata (in_sample),
      .re    (grd_re),
      .raddr (grd_raddr[k]),
      .rdata (grd_rdata[k])
    );
  end

  // --------------------------------------------------------------------------
  // Arithmetic
  // --------------------------------------------------------------------------
  math_ctl_t     math_ctl;
  logic [SW-1:0] math_value;
  logic          math_sat;

  assign math_ctl.ld_lap  = (state_r == S_LAP);
  assign math_ctl.ld_prod = (state_r == S_MUL);

  pads_math #(
    .SAMPLE_BITS (SW)
  ) u_math (
    .clk       (clk),
    .ctl       (math_ctl),
    .gain      (gain_r),
    .ctr       (ctr_r),
    .nbr_n     (nbr_n_r),
    .nbr_s     (nbr_s_r),
    .nbr_w     (grd_rdata[0]),
    .nbr_e     (grd_rdata[1]),
    .adv       (grd_rdata[2]),
    .value     (math_value),
    .saturated (math_sat)
  );

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_value_r, out_value_nxt;
  logic          out_sat_r, out_sat_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_rng) begin
          if (in_operation == OP_WRITE) begin
            state_nxt = S_WFLAG;
          end else if (fill_stat.full) begin
            state_nxt = S_RD0;
          end
        end
      end
      S_WFLAG: state_nxt = S_IDLE;
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_LAP;
      S_LAP:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = math_value;
          out_sat_nxt   = math_sat;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTHESIS
  // no beat taken during the flag sweep
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    fill_stat.clearing |-> !in_ready)
    else $error("input accepted during flag sweep");

  // an in-range write always runs the flag update next
  a_write_commits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_rng && (in_operation == OP_WRITE)) |=> (state_r == S_WFLAG))
    else $error("write beat skipped flag update");

  // a completed compute lands in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SUM) && (!out_valid_r || out_ready))
      |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("compute result not loaded");

  // frame stays complete once complete
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fill_stat.full |=> fill_stat.full)
    else $error("fill count dropped");
`endif

endmodule
